FILE: rtl/esbrt_pkg.sv
// Package for the exact-size buffer recycle table.
// Holds the table depth, index width, word and entry types and the sequencer states.
// Depends on nothing; every other source file but esbrt_ram imports it.
`timescale 1ns / 1ps

package esbrt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int SIZE_W   = 24;
    localparam int HANDLE_W = 32;

    localparam logic ACT_TAKE = 1'b0;
    localparam logic ACT_GIVE = 1'b1;

    typedef struct packed {
        logic                action;
        logic [SIZE_W-1:0]   block_size;
        logic [HANDLE_W-1:0] block_handle;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] out_handle;
        logic                dropped;
    } rsp_t;

    typedef struct packed {
        logic                valid;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/esbrt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; used for the entry table of the buffer recycle table.
`timescale 1ns / 1ps

module esbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/esbrt_cmp.sv
// Shared compare unit of the buffer recycle table: decides whether one entry serves a request.
// Depends on esbrt_pkg for the entry type and action codes.
`timescale 1ns / 1ps

module esbrt_cmp
    import esbrt_pkg::*;
(
    input  logic              action,
    input  logic [SIZE_W-1:0] key_size,
    input  entry_t            entry,
    output logic              match
);

    // A take wants an occupied entry of exactly the requested size;
    // a give wants any free entry.
    always_comb
    begin
        case (action)
            ACT_TAKE: match = entry.valid && (entry.size == key_size);
            ACT_GIVE: match = !entry.valid;
            default:  match = 1'b0;
        endcase
    end

endmodule

FILE: rtl/exact_size_buffer_recycle_table.sv
// Top level of the exact-size buffer recycle table: sequencer, result register, table RAM.
// Depends on esbrt_pkg, esbrt_ram and esbrt_cmp.
`timescale 1ns / 1ps

// How to use the block:
// A request word (req) carries an action, a block size and a handle. It is accepted
// on a rising edge where req_valid is high and req_stall is low. A take looks for the
// lowest-index occupied entry of exactly that size, frees it and returns its handle
// with hit set. A give stores size and handle in the lowest free entry, or returns
// dropped set when every entry is occupied. A give with a null handle stores nothing
// and returns an all-zero word. Exactly one response word (rsp) follows each request.
// The table is walked one entry per cycle through the single read port of the RAM;
// the walk stops at the first matching entry. One request is in work at a time;
// req_stall is high from acceptance until the response has been moved into the
// output register. The response register holds its word while rsp_stall is high.
// A new request can be accepted while an earlier response still waits there; the
// finished result of that request then waits inside until the register frees up.
// After reset the block runs a clearing pass that writes every one of the
// TABLE_ENTRIES entries free, one per cycle; req_stall is high during that pass.

module exact_size_buffer_recycle_table
    import esbrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    req_t             req_reg, req_next;
    rsp_t             res_reg, res_next;
    rsp_t             out_word_reg, out_word_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             match;
    logic             load_out;

    // Entry table: valid bit, size and handle in one word.
    esbrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The one compare unit, reused for every entry of the walk.
    esbrt_cmp u_cmp (
        .action   (req_reg.action),
        .key_size (req_reg.block_size),
        .entry    (rd_data),
        .match    (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '0;
        rd_addr    = idx_reg;
        load_out   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Clearing pass: write every entry free.
                wr_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                // Entry 0 is read ahead so its data is there in the first check cycle.
                rd_addr  = '0;
                idx_next = '0;
                if (req_valid)
                begin
                    req_next = req;
                    if ((req.action == ACT_GIVE) && (req.block_handle == '0))
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // rd_data holds the entry at idx_reg.
                if (match)
                begin
                    wr_en = 1'b1;
                    res_next = '0;
                    if (req_reg.action == ACT_GIVE)
                    begin
                        wr_data.valid  = 1'b1;
                        wr_data.size   = req_reg.block_size;
                        wr_data.handle = req_reg.block_handle;
                    end
                    else
                    begin
                        res_next.hit        = 1'b1;
                        res_next.out_handle = rd_data.handle;
                    end
                    state_next = ST_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    // Walk ended without a match: a miss for a take, a full table for a give.
                    res_next         = '0;
                    res_next.dropped = (req_reg.action == ACT_GIVE);
                    state_next       = ST_DONE;
                end
                else
                begin
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free or draining.
                if (!out_valid_reg || !rsp_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res_reg;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

endmodule

FILE: rtl/esbrt_check.sv
// Port-level checker for the exact-size buffer recycle table, bound to the top level.
// Depends on esbrt_pkg for the word types.
`timescale 1ns / 1ps

module esbrt_check
    import esbrt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled response word stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("response word changed while stalled");

    // A word never reports both a hit and a drop.
    a_hit_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.dropped))
        else $error("hit and dropped set together");

    // Without a hit the handle reads as null.
    a_miss_null: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.hit) |-> (rsp.out_handle == '0))
        else $error("non-null handle without a hit");

    // Only one request is in work: acceptance closes the request side.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request accepted while one is in work");

endmodule

bind exact_size_buffer_recycle_table esbrt_check u_esbrt_check (.*);

FILE: bench/exact_size_buffer_recycle_table_test.sv
// Self-checking bench for the exact-size buffer recycle table.
// Holds a scoreboard class with its own copy of the table, plus the drive and pacing processes.
// Depends on esbrt_pkg and the exact_size_buffer_recycle_table top level.
`timescale 1ns / 1ps

module exact_size_buffer_recycle_table_test
    import esbrt_pkg::*;
();

    localparam int     HALF_NS      = 10;
    localparam int     RESET_CYCLES = 7;
    localparam int     POOL_SIZES   = 8;
    localparam int     HOLD_CYCLES  = 3000;
    localparam int     HOLD_AT      = 40;
    localparam int     MIX_A_WORDS  = 300;
    localparam int     MIX_B_WORDS  = 260;
    // Several times the slowest legal run, in which every
    // request walks the whole table.
    localparam longint LIMIT_NS     = 64'd160_000_000;

    // The scoreboard mirrors the table. Each accepted request word updates the mirror
    // right away and queues the response word that the block must produce for it.
    class recycle_book;
        bit                  occupied [TABLE_ENTRIES];
        logic [SIZE_W-1:0]   sizes    [TABLE_ENTRIES];
        logic [HANDLE_W-1:0] handles  [TABLE_ENTRIES];
        rsp_t                awaited  [$];
        int                  in_use;
        int                  peak;
        int                  errors;
        int                  checked;
        int                  hits;
        int                  misses;
        int                  drops;
        int                  null_gives;

        function void note(req_t w);
            rsp_t r;
            int   slot;
            int   i;
            r    = '0;
            slot = -1;
            if (w.action == ACT_TAKE)
            begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (occupied[i] && sizes[i] == w.block_size)
                    begin
                        slot = i;
                        break;
                    end
                end
                if (slot >= 0)
                begin
                    r.hit          = 1'b1;
                    r.out_handle   = handles[slot];
                    occupied[slot] = 1'b0;
                    in_use--;
                    hits++;
                end
                else
                begin
                    misses++;
                end
            end
            else if (w.block_handle == '0)
            begin
                null_gives++;
            end
            else
            begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!occupied[i])
                    begin
                        slot = i;
                        break;
                    end
                end
                if (slot >= 0)
                begin
                    occupied[slot] = 1'b1;
                    sizes[slot]    = w.block_size;
                    handles[slot]  = w.block_handle;
                    in_use++;
                    if (in_use > peak)
                        peak = in_use;
                end
                else
                begin
                    r.dropped = 1'b1;
                    drops++;
                end
            end
            awaited.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("response word %p arrived with nothing outstanding", got));
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                if (got.hit !== want.hit)
                    report($sformatf("response %0d hit %b, expected %b",
                                     checked, got.hit, want.hit));
                if (got.out_handle !== want.out_handle)
                    report($sformatf("response %0d out_handle %h, expected %h",
                                     checked, got.out_handle, want.out_handle));
                if (got.dropped !== want.dropped)
                    report($sformatf("response %0d dropped %b, expected %b",
                                     checked, got.dropped, want.dropped));
            end
        endtask
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    recycle_book book = new();

    // A small set of sizes that most requests draw from, so that takes find the
    // buffers that earlier gives put back. Zero and the largest size are in it.
    logic [SIZE_W-1:0] size_pool [POOL_SIZES];
    int                sent;
    bit                held_off;

    exact_size_buffer_recycle_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #(HALF_NS) clk = 1'b1;
        #(HALF_NS) clk = 1'b0;
    end

    function automatic req_t make_word(logic act, logic [SIZE_W-1:0] sz,
                                       logic [HANDLE_W-1:0] hd);
        req_t w;
        w.action       = act;
        w.block_size   = sz;
        w.block_handle = hd;
        return w;
    endfunction

    // Mostly sizes from the pool; now and then a size from the full range, which
    // for a take is nearly always a miss that walks the whole table.
    function automatic req_t random_word(int give_pct);
        req_t w;
        int   pick;
        w.action = ($urandom_range(99) < give_pct) ? ACT_GIVE : ACT_TAKE;
        if ($urandom_range(99) < 85)
            w.block_size = size_pool[$urandom_range(POOL_SIZES - 1)];
        else
            w.block_size = SIZE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 5)
            w.block_handle = '0;
        else if (pick < 8)
            w.block_handle = '1;
        else
            w.block_handle = $urandom;
        return w;
    endfunction

    // Offers one request word. It is called just after a falling edge and returns just
    // after the falling edge that follows acceptance. The sender idles in about one
    // cycle of ten, except in a quiet stretch of one hundred words.
    task automatic offer(input req_t w);
        bit calm;
        calm = (sent >= 120 && sent < 220);
        while (!calm && $urandom_range(99) < 10)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        book.note(w);
        sent++;
        @(negedge clk);
    endtask

    // Response checking happens at the rising edge, against the stall value that was
    // set up at the previous falling edge.
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            book.check(rsp);
    end

    // Receiver pacing. Once a few dozen responses have come back the receiver holds
    // off for a long stretch while the sender keeps offering, so that the response
    // register and the internal result slot both fill and the block stalls its input.
    // Outside that, it stalls about one cycle in ten, with a quiet stretch.
    initial
    begin : rsp_pacing
        bit calm;
        forever
        begin
            @(negedge clk);
            if (!held_off && book.checked >= HOLD_AT)
            begin
                held_off = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    rsp_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            calm = (book.checked >= 200 && book.checked < 350);
            rsp_stall <= (!calm && $urandom_range(99) < 10);
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("exact_size_buffer_recycle_table test failed");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        size_pool[0] = '0;
        size_pool[1] = '1;
        for (i = 2; i < POOL_SIZES; i++)
            size_pool[i] = ($urandom_range(1)) ? SIZE_W'($urandom_range(4096, 1))
                                               : SIZE_W'($urandom);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed words. The block is still in its clearing pass here, so the first
        // word also checks that the input stays stalled until the pass is over.
        offer(make_word(ACT_TAKE, 24'h000000, 32'h0000_0000)); // size zero on empty table
        offer(make_word(ACT_TAKE, 24'hFFFFFF, 32'hFFFF_FFFF));
        offer(make_word(ACT_GIVE, 24'h000000, 32'h0000_0001)); // size zero is stored
        offer(make_word(ACT_GIVE, 24'h000005, 32'h0000_0000)); // null handle, no store
        offer(make_word(ACT_TAKE, 24'h000005, 32'h0000_0000)); // must miss
        offer(make_word(ACT_TAKE, 24'h000000, 32'h0000_0000)); // hits the stored zero
        offer(make_word(ACT_TAKE, 24'h000000, 32'h0000_0000)); // free entries never match
        offer(make_word(ACT_GIVE, 24'hFFFFFF, 32'hFFFF_FFFF));
        offer(make_word(ACT_GIVE, 24'hFFFFFF, 32'hA5A5_A5A5));
        offer(make_word(ACT_GIVE, 24'hFFFFFF, 32'hFFFF_FFFF)); // duplicate handle kept
        offer(make_word(ACT_TAKE, 24'hFFFFFF, 32'h0000_0000)); // lowest index wins
        offer(make_word(ACT_GIVE, 24'h123456, 32'h0BAD_F00D)); // reuses the freed hole
        offer(make_word(ACT_TAKE, 24'hFFFFFF, 32'h5A5A_5A5A));
        offer(make_word(ACT_TAKE, 24'hFFFFFF, 32'h0000_0000));
        offer(make_word(ACT_TAKE, 24'hFFFFFF, 32'h0000_0000)); // all copies gone
        offer(make_word(ACT_TAKE, 24'h123456, 32'h0000_0000));
        offer(make_word(ACT_GIVE, 24'hFFFFFF, 32'h0000_0000));
        offer(make_word(ACT_GIVE, 24'h000001, 32'h8000_0000));
        offer(make_word(ACT_TAKE, 24'h000001, 32'hFFFF_FFFF)); // handle field ignored
        offer(make_word(ACT_GIVE, 24'h800000, 32'h0000_0001));
        offer(make_word(ACT_TAKE, 24'h800000, 32'h0000_0000));

        // First random mix, leaning toward gives so that occupancy grows over time.
        for (i = 0; i < MIX_A_WORDS; i++)
            offer(random_word(55));

        // Second random mix with gives and takes in balance.
        for (i = 0; i < MIX_B_WORDS; i++)
            offer(random_word(50));

        req_valid <= 1'b0;
        while (book.awaited.size() != 0)
            @(posedge clk);
        // Any stray response would show up within one more full walk.
        repeat (TABLE_ENTRIES + 8) @(posedge clk);

        $display("Run covered %0d requests and %0d responses: %0d hits, %0d misses,",
                 sent, book.checked, book.hits, book.misses);
        $display("%0d dropped gives, %0d null gives, peak occupancy %0d of %0d entries.",
                 book.drops, book.null_gives, book.peak, TABLE_ENTRIES);
        if (book.errors == 0)
            $display("exact_size_buffer_recycle_table test passed");
        else
            $display("exact_size_buffer_recycle_table test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/esbrt_pkg.sv
rtl/esbrt_ram.sv
rtl/esbrt_cmp.sv
rtl/exact_size_buffer_recycle_table.sv
rtl/esbrt_check.sv
bench/exact_size_buffer_recycle_table_test.sv
